// ===== design/mbm_pkg.sv =====
// Shared types, address constants and the boot image for the handheld memory bus map.
package mbm_pkg;

	localparam int unsigned ADDR_W = 16;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned STORE_DEPTH = 65536;
	localparam int unsigned BOOT_DEPTH = 256;
	localparam int unsigned CMD_DEPTH_DEF = 2;
	localparam int unsigned OUT_DEPTH_DEF = 4;

	localparam logic [15:0] CART_ROM_END = 16'h7FFF;
	localparam logic [15:0] EXT_RAM_START = 16'hA000;
	localparam logic [15:0] EXT_RAM_END = 16'hBFFF;
	localparam logic [15:0] BOOT_SIZE = 16'h0100;
	localparam logic [15:0] ADDR_ECHO = 16'hE000;
	localparam logic [15:0] ADDR_ECHO_END = 16'hFDFF;
	localparam logic [15:0] ECHO_OFFSET = 16'h2000;
	localparam logic [15:0] ADDR_P1 = 16'hFF00;
	localparam logic [15:0] ADDR_DIV = 16'hFF04;
	localparam logic [15:0] ADDR_TIMA = 16'hFF05;
	localparam logic [15:0] ADDR_IF = 16'hFF0F;
	localparam logic [15:0] ADDR_LY = 16'hFF44;
	localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;

	localparam logic [7:0] P1_KEEP_MASK = 8'b0000_1111;
	localparam logic [7:0] P1_SEL_MASK = 8'b0011_0000;
	localparam logic [7:0] P1_FIXED = 8'b1100_0000;

	typedef enum logic [2:0] {
		OP_CPU_READ = 3'd0,
		OP_CPU_WRITE = 3'd1,
		OP_TIMER_WRITE = 3'd2,
		OP_VIDEO_WRITE = 3'd3,
		OP_RAISE_IRQ = 3'd4,
		OP_BOOT_DONE = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE = 3'd0,
		ACT_RAM_RD = 3'd1,
		ACT_RAM_WR = 3'd2,
		ACT_P1_RD = 3'd3,
		ACT_P1_WR = 3'd4,
		ACT_IF_RD = 3'd5,
		ACT_IF_WR = 3'd6,
		ACT_IF_SET = 3'd7
	} act_t;

	typedef struct packed {
		act_t act;
		logic [15:0] addr;
		logic [7:0] data;
		logic to_cart;
		logic cart_write;
		logic rejected;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic to_cartridge;
		logic cart_write;
		logic [15:0] cart_address;
		logic [7:0] cart_data;
		logic rejected;
	} res_t;

	localparam logic [7:0] BOOT_ROM [BOOT_DEPTH] = '{
		8'h31,8'hFE,8'hFF,8'hAF,8'h21,8'hFF,8'h9F,8'h32,8'hCB,8'h7C,8'h20,8'hFB,8'h21,8'h26,8'hFF,8'h0E,
		8'h11,8'h3E,8'h80,8'h32,8'hE2,8'h0C,8'h3E,8'hF3,8'hE2,8'h32,8'h3E,8'h77,8'h77,8'h3E,8'hFC,8'hE0,
		8'h47,8'h11,8'h04,8'h01,8'h21,8'h10,8'h80,8'h1A,8'hCD,8'h95,8'h00,8'hCD,8'h96,8'h00,8'h13,8'h7B,
		8'hFE,8'h34,8'h20,8'hF3,8'h11,8'hD8,8'h00,8'h06,8'h08,8'h1A,8'h13,8'h22,8'h23,8'h05,8'h20,8'hF9,
		8'h3E,8'h19,8'hEA,8'h10,8'h99,8'h21,8'h2F,8'h99,8'h0E,8'h0C,8'h3D,8'h28,8'h08,8'h32,8'h0D,8'h20,
		8'hF9,8'h2E,8'h0F,8'h18,8'hF3,8'h67,8'h3E,8'h64,8'h57,8'hE0,8'h42,8'h3E,8'h91,8'hE0,8'h40,8'h04,
		8'h1E,8'h02,8'h0E,8'h0C,8'hF0,8'h44,8'hFE,8'h90,8'h20,8'hFA,8'h0D,8'h20,8'hF7,8'h1D,8'h20,8'hF2,
		8'h0E,8'h13,8'h24,8'h7C,8'h1E,8'h83,8'hFE,8'h62,8'h28,8'h06,8'h1E,8'hC1,8'hFE,8'h64,8'h20,8'h06,
		8'h7B,8'hE2,8'h0C,8'h3E,8'h87,8'hF2,8'hF0,8'h42,8'h90,8'hE0,8'h42,8'h15,8'h20,8'hD2,8'h05,8'h20,
		8'h4F,8'h16,8'h20,8'h18,8'hCB,8'h4F,8'h06,8'h04,8'hC5,8'hCB,8'h11,8'h17,8'hC1,8'hCB,8'h11,8'h17,
		8'h05,8'h20,8'hF5,8'h22,8'h23,8'h22,8'h23,8'hC9,8'hCE,8'hED,8'h66,8'h66,8'hCC,8'h0D,8'h00,8'h0B,
		8'h03,8'h73,8'h00,8'h83,8'h00,8'h0C,8'h00,8'h0D,8'h00,8'h08,8'h11,8'h1F,8'h88,8'h89,8'h00,8'h0E,
		8'hDC,8'hCC,8'h6E,8'hE6,8'hDD,8'hDD,8'hD9,8'h99,8'hBB,8'hBB,8'h67,8'h63,8'h6E,8'h0E,8'hEC,8'hCC,
		8'hDD,8'hDC,8'h99,8'h9F,8'hBB,8'hB9,8'h33,8'h3E,8'h3C,8'h42,8'hB9,8'hA5,8'hB9,8'hA5,8'h42,8'h4C,
		8'h21,8'h04,8'h01,8'h11,8'hA8,8'h00,8'h1A,8'h13,8'hBE,8'h20,8'hFE,8'h23,8'h7D,8'hFE,8'h34,8'h20,
		8'hF5,8'h06,8'h19,8'h78,8'h86,8'h23,8'h05,8'h20,8'hFB,8'h86,8'h20,8'hFE,8'h3E,8'h01,8'hE0,8'h50
	};

endpackage

// ===== design/mbm_ram.sv =====
// Generic single-port RAM with registered read data.
module mbm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/mbm_fifo.sv =====
// Small register queue; the depth must be a power of two.
module mbm_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/mbm_front.sv =====
// Front end: classifies each request by address and operation and tracks boot mode.
module mbm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                accept,
	input  logic [2:0]          operation,
	input  logic [15:0]         address,
	input  logic [7:0]          write_data,
	input  logic [2:0]          irq_bit,
	input  logic [3:0]          button_row,
	input  logic [3:0]          direction_row,
	output mbm_pkg::cmd_t       cmd
);

	logic        in_boot_q;
	logic        boot_clr;
	logic        in_echo;
	logic        to_cart;
	logic [15:0] echo_addr;

	always_comb begin
		in_echo = (address >= mbm_pkg::ADDR_ECHO) && (address <= mbm_pkg::ADDR_ECHO_END);
		to_cart = ((address <= mbm_pkg::CART_ROM_END)
			|| ((address >= mbm_pkg::EXT_RAM_START) && (address <= mbm_pkg::EXT_RAM_END)))
			&& !(in_boot_q && (address < mbm_pkg::BOOT_SIZE));
		echo_addr = address - mbm_pkg::ECHO_OFFSET;
		boot_clr = 1'b0;
		cmd = '0;
		cmd.act = mbm_pkg::ACT_NONE;
		cmd.addr = address;
		cmd.data = write_data;
		case (mbm_pkg::op_t'(operation))
			mbm_pkg::OP_CPU_READ: begin
				if (in_echo) begin
					cmd.act = mbm_pkg::ACT_RAM_RD;
					cmd.addr = echo_addr;
				end else if (to_cart) begin
					cmd.to_cart = 1'b1;
				end else if (address == mbm_pkg::ADDR_P1) begin
					cmd.act = mbm_pkg::ACT_P1_RD;
					cmd.data = {direction_row, button_row};
				end else if (address == mbm_pkg::ADDR_IF) begin
					cmd.act = mbm_pkg::ACT_IF_RD;
				end else begin
					cmd.act = mbm_pkg::ACT_RAM_RD;
				end
			end
			mbm_pkg::OP_CPU_WRITE: begin
				if (in_echo) begin
					cmd.act = mbm_pkg::ACT_RAM_WR;
					cmd.addr = echo_addr;
				end else if (to_cart) begin
					cmd.to_cart = 1'b1;
					cmd.cart_write = 1'b1;
				end else if ((address == mbm_pkg::ADDR_LY) || (address == mbm_pkg::ADDR_DIV)) begin
					cmd.act = mbm_pkg::ACT_RAM_WR;
					cmd.data = '0;
				end else if (address == mbm_pkg::ADDR_P1) begin
					cmd.act = mbm_pkg::ACT_P1_WR;
				end else if (address == mbm_pkg::ADDR_IF) begin
					cmd.act = mbm_pkg::ACT_IF_WR;
				end else begin
					cmd.act = mbm_pkg::ACT_RAM_WR;
					boot_clr = (address == mbm_pkg::ADDR_BOOT_OFF);
				end
			end
			mbm_pkg::OP_TIMER_WRITE: begin
				if ((address == mbm_pkg::ADDR_DIV) || (address == mbm_pkg::ADDR_TIMA)) begin
					cmd.act = mbm_pkg::ACT_RAM_WR;
				end else begin
					cmd.rejected = 1'b1;
				end
			end
			mbm_pkg::OP_VIDEO_WRITE: begin
				if (address == mbm_pkg::ADDR_LY) begin
					cmd.act = mbm_pkg::ACT_RAM_WR;
				end else begin
					cmd.rejected = 1'b1;
				end
			end
			mbm_pkg::OP_RAISE_IRQ: begin
				cmd.act = mbm_pkg::ACT_IF_SET;
				cmd.data = 8'(1) << irq_bit;
			end
			mbm_pkg::OP_BOOT_DONE: begin
				boot_clr = 1'b1;
			end
			default: begin
				cmd.act = mbm_pkg::ACT_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_boot_q <= 1'b1;
		end else if (cfg_we) begin
			in_boot_q <= cfg_wdata;
		end else if (accept && boot_clr) begin
			in_boot_q <= 1'b0;
		end
	end

endmodule

// ===== design/mbm_back.sv =====
// Back end: writes boot image and zeros to the store after reset, then runs requests in order
module mbm_back #(
	parameter int unsigned OUT_DEPTH = mbm_pkg::OUT_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  mbm_pkg::cmd_t                  cmd,
	output logic                           cmd_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                           res_push,
	output mbm_pkg::res_t                  res,
	output logic                           clear_done
);

	localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
	localparam int unsigned AW = $clog2(mbm_pkg::STORE_DEPTH);
	localparam int unsigned BW = $clog2(mbm_pkg::BOOT_DEPTH);

	logic [AW-1:0]   clr_addr_q;
	logic            clr_done_q;
	logic [7:0]      p1_q;
	logic [7:0]      if_q;
	logic            room;
	logic            ram_we;
	logic [AW-1:0]   ram_addr;
	logic [7:0]      ram_wdata;
	logic [7:0]      ram_rdata;
	logic [7:0]      reg_rd;
	logic            valid_s2;
	logic            from_ram_s2;
	logic [7:0]      rd_s2;
	logic            to_cart_s2;
	logic            cart_write_s2;
	logic [15:0]     cart_addr_s2;
	logic [7:0]      cart_data_s2;
	logic            rejected_s2;

	assign room = ({1'b0, out_count} + (CNT_W + 1)'(valid_s2)) < (CNT_W + 1)'(OUT_DEPTH);
	assign cmd_pop = clr_done_q && cmd_valid && room;
	assign clear_done = clr_done_q;

	always_comb begin
		if (!clr_done_q) begin
			ram_we = 1'b1;
			ram_addr = clr_addr_q;
			ram_wdata = (clr_addr_q < AW'(mbm_pkg::BOOT_DEPTH))
				? mbm_pkg::BOOT_ROM[clr_addr_q[BW-1:0]] : 8'h00;
		end else begin
			ram_we = cmd_pop && (cmd.act == mbm_pkg::ACT_RAM_WR);
			ram_addr = cmd.addr[AW-1:0];
			ram_wdata = cmd.data;
		end
	end

	always_comb begin
		reg_rd = '0;
		case (cmd.act)
			mbm_pkg::ACT_P1_RD: begin
				reg_rd = mbm_pkg::P1_FIXED | (p1_q & mbm_pkg::P1_SEL_MASK);
				if (!p1_q[5]) begin
					reg_rd = reg_rd | {4'h0, cmd.data[7:4]};
				end
				if (!p1_q[4]) begin
					reg_rd = reg_rd | {4'h0, cmd.data[3:0]};
				end
			end
			mbm_pkg::ACT_IF_RD: begin
				reg_rd = if_q;
			end
			default: begin
				reg_rd = '0;
			end
		endcase
	end

	mbm_ram #(
		.WIDTH(mbm_pkg::DATA_W),
		.DEPTH(mbm_pkg::STORE_DEPTH)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_done_q <= 1'b0;
			p1_q <= '0;
			if_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (!clr_done_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == '1) begin
					clr_done_q <= 1'b1;
				end
			end
			valid_s2 <= cmd_pop;
			if (cmd_pop) begin
				case (cmd.act)
					mbm_pkg::ACT_P1_WR: begin
						p1_q <= (p1_q & mbm_pkg::P1_KEEP_MASK) | (cmd.data & mbm_pkg::P1_SEL_MASK)
							| mbm_pkg::P1_FIXED;
					end
					mbm_pkg::ACT_IF_WR: begin
						if_q <= cmd.data;
					end
					mbm_pkg::ACT_IF_SET: begin
						if_q <= if_q | cmd.data;
					end
					default: begin
						if_q <= if_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			from_ram_s2 <= (cmd.act == mbm_pkg::ACT_RAM_RD);
			rd_s2 <= reg_rd;
			to_cart_s2 <= cmd.to_cart;
			cart_write_s2 <= cmd.cart_write;
			cart_addr_s2 <= cmd.to_cart ? cmd.addr : 16'h0000;
			cart_data_s2 <= cmd.cart_write ? cmd.data : 8'h00;
			rejected_s2 <= cmd.rejected;
		end
	end

	assign res_push = valid_s2;

	always_comb begin
		res.read_data = from_ram_s2 ? ram_rdata : rd_s2;
		res.to_cartridge = to_cart_s2;
		res.cart_write = cart_write_s2;
		res.cart_address = cart_addr_s2;
		res.cart_data = cart_data_s2;
		res.rejected = rejected_s2;
	end

endmodule

// ===== design/handheld_memory_bus_map.sv =====
// Top level of the handheld memory bus map: front end, request queue, back end, result queue.
//
//   channel   handshake         payload
//   request   push / full       operation address write_data irq_bit button_row direction_row
//   result    pop / empty       read_data to_cartridge cart_write cart_address cart_data rejected
//   config    cfg_we            cfg_wdata (start in boot mode)
//
// One request is taken per clock while full is low; its result passes the request queue,
// the back-end result register and the result queue. The single byte store port is used at
// most once per request, which sets that rate. After reset the store is swept once over all
// 65536 addresses, loading the boot image and zeros; full stays high for that whole pass.
// When results are not popped the queues fill and full rises; nothing is dropped.
module handheld_memory_bus_map #(
	parameter int unsigned CMD_DEPTH = mbm_pkg::CMD_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH = mbm_pkg::OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  operation,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [2:0]  irq_bit,
	input  logic [3:0]  button_row,
	input  logic [3:0]  direction_row,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  read_data,
	output logic        to_cartridge,
	output logic        cart_write,
	output logic [15:0] cart_address,
	output logic [7:0]  cart_data,
	output logic        rejected
);

	localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);
	localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	mbm_pkg::cmd_t          front_cmd;
	mbm_pkg::cmd_t          back_cmd;
	mbm_pkg::res_t          back_res;
	mbm_pkg::res_t          out_res;
	logic                   accept;
	logic                   cmd_full;
	logic                   cmd_empty;
	logic                   cmd_pop;
	logic [CMD_CNT_W-1:0]   cmd_count;
	logic                   res_push;
	logic                   out_full;
	logic [OUT_CNT_W-1:0]   out_count;
	logic                   clear_done;

	assign full = cmd_full || !clear_done;
	assign accept = push && !full;

	mbm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.accept(accept),
		.operation(operation),
		.address(address),
		.write_data(write_data),
		.irq_bit(irq_bit),
		.button_row(button_row),
		.direction_row(direction_row),
		.cmd(front_cmd)
	);

	mbm_fifo #(
		.WIDTH($bits(mbm_pkg::cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.wdata(front_cmd),
		.full(cmd_full),
		.pop(cmd_pop),
		.rdata(back_cmd),
		.empty(cmd_empty),
		.count(cmd_count)
	);

	mbm_back #(
		.OUT_DEPTH(OUT_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(!cmd_empty),
		.cmd(back_cmd),
		.cmd_pop(cmd_pop),
		.out_count(out_count),
		.res_push(res_push),
		.res(back_res),
		.clear_done(clear_done)
	);

	mbm_fifo #(
		.WIDTH($bits(mbm_pkg::res_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(back_res),
		.full(out_full),
		.pop(pop),
		.rdata(out_res),
		.empty(empty),
		.count(out_count)
	);

	assign read_data = out_res.read_data;
	assign to_cartridge = out_res.to_cartridge;
	assign cart_write = out_res.cart_write;
	assign cart_address = out_res.cart_address;
	assign cart_data = out_res.cart_data;
	assign rejected = out_res.rejected;

	a_no_result_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && out_full))
		else $error("result produced while the result queue is full");

	a_queue_idle_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_done |-> (cmd_count == '0) && !res_push)
		else $error("request activity during the store clearing pass");

	a_cart_fields_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !to_cartridge) |-> (cart_address == 16'h0000) && !cart_write
			&& (cart_data == 8'h00))
		else $error("cartridge fields set on a non-forwarded result");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rejected) |-> !to_cartridge && (read_data == 8'h00))
		else $error("rejected result carries data or a forward");

endmodule
